### rtl/core/escpi_pkg.sv
// Shared types, widths and helper functions for the encoder speed PI controller.
// Used by every module of the block; depends on nothing else.
package escpi_pkg;

  // Field widths.
  localparam int POSITION_BITS = 10;
  localparam int TICK_W        = 4;
  localparam int SPEED_W       = 16;
  localparam int TARGET_W      = 13;
  localparam int GAIN_W        = 16;
  localparam int DRIVE_W       = 24;
  localparam int OFFSET_W      = 16;
  localparam int FRAC_BITS     = 8;

  // Encoder travel: a difference of two positions, and the sum of two travels.
  localparam int POS_DIFF_W = POSITION_BITS + 1;
  localparam int POS_SUM_W  = POSITION_BITS + 2;

  // PI terms: error times a zero-extended gain, then the Q8.8 fraction dropped.
  localparam int ERR_W       = SPEED_W + 1;
  localparam int GAIN_PROD_W = ERR_W + GAIN_W + 1;
  localparam int TERM_W      = GAIN_PROD_W - FRAC_BITS;

  // Interpolation: the output step with offset, and its magnitude times (tick + 1).
  localparam int INTERP_STEPS = 9;
  localparam int STEP_W       = DRIVE_W + 2;
  localparam int MAG_W        = (STEP_W - 1) + (TICK_W + 1);

  // Division by the step count as a multiplication by a rounded-up reciprocal.
  // With this shift the quotient is exact for every magnitude below 2**MAG_W.
  localparam int RECIP_SHIFT = MAG_W + $clog2(INTERP_STEPS);
  localparam int RECIP_W     = MAG_W + 1;
  localparam int QUOT_W      = MAG_W + RECIP_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_STEPS =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(INTERP_STEPS - 1)) / 64'(INTERP_STEPS));

  // Width in which drive sums are formed before they are clamped or saturated.
  localparam int CLAMP_W = QUOT_W + 2;

  // Configuration port.
  localparam int NUM_REGS  = 6;
  localparam int APB_W     = 32;
  localparam int ADDR_W    = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_TARGET_SPEED = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN    = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN   = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_MAX    = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_MIN    = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_STEP_OFFSET  = REG_IDX_W'(5);

  // Item kinds.
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Full-scale drive values.
  localparam logic signed [DRIVE_W-1:0] DRIVE_FULL_MAX = {1'b0, {(DRIVE_W - 1){1'b1}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_FULL_MIN = {1'b1, {(DRIVE_W - 1){1'b0}}};

  typedef struct packed {
    logic                     kind;
    logic [POSITION_BITS-1:0] left_position;
    logic [POSITION_BITS-1:0] right_position;
    logic [TICK_W-1:0]        tick_index;
  } item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] motor_drive;
    logic signed [SPEED_W-1:0] measured_speed;
  } result_t;

  typedef struct packed {
    logic signed [TARGET_W-1:0] target_speed;
    logic [GAIN_W-1:0]          prop_gain;
    logic [GAIN_W-1:0]          integ_gain;
    logic signed [DRIVE_W-1:0]  drive_max;
    logic signed [DRIVE_W-1:0]  drive_min;
    logic [OFFSET_W-1:0]        step_offset;
  } cfg_t;

  // Beat from the speed stage to the PI stages.
  typedef struct packed {
    logic                      kind;
    logic [TICK_W-1:0]         tick_index;
    logic signed [ERR_W-1:0]   err;
    logic signed [SPEED_W-1:0] speed;
  } spd_item_t;

  // Beat from the PI stages to the interpolation stages.
  typedef struct packed {
    logic                      kind;
    logic signed [SPEED_W-1:0] speed;
    logic                      neg;
    logic [MAG_W-1:0]          mag;
    logic signed [DRIVE_W-1:0] out_old;
  } stp_item_t;

  // Clamp to the configured limits; the upper limit is tested first.
  function automatic logic signed [DRIVE_W-1:0] clamp_drive(
    input logic signed [CLAMP_W-1:0] x,
    input logic signed [DRIVE_W-1:0] hi,
    input logic signed [DRIVE_W-1:0] lo
  );
    logic signed [DRIVE_W-1:0] r;
    if (x > CLAMP_W'(hi)) begin
      r = hi;
    end else if (x < CLAMP_W'(lo)) begin
      r = lo;
    end else begin
      r = x[DRIVE_W-1:0];
    end
    return r;
  endfunction

  // Saturate to the full signed drive range.
  function automatic logic signed [DRIVE_W-1:0] sat_drive(
    input logic signed [CLAMP_W-1:0] x
  );
    return clamp_drive(x, DRIVE_FULL_MAX, DRIVE_FULL_MIN);
  endfunction

endpackage

### rtl/core/encoder_speed_pi_controller_core.sv
// Top level of the encoder speed PI controller: register port and item pipeline.
// Depends on escpi_pkg, escpi_regs, escpi_speed, escpi_pi and escpi_interp.
//
// Usage:
//   Items arrive on item/item_valid and are taken at a rising edge where
//   item_valid is high and item_stall is low. An update item (kind 0) carries
//   the two absolute encoder positions; a tick item (kind 1) carries the tick
//   count since the last update. Every item produces exactly one result beat
//   on result/result_valid, taken when result_stall is low.
//   The item path is a seven-register pipeline: input register, speed stage,
//   gain products, integrator, output update with tick step product, reciprocal
//   product, result register. One item is taken every cycle while the receiver
//   does not stall. Each piece of state lives in a single stage, so consecutive
//   items see each other's updates in order. When the receiver stalls, each
//   stage holds its beat and the pipeline keeps filling its empty stages;
//   item_stall rises only once no stage can move. The gains, target, limits
//   and step offset are written through the APB port while no item is in
//   flight; the user, not the block, must ensure this. pready is always high.
//   Reset (rst, synchronous) empties the pipeline, clears the encoder, speed,
//   integrator and output state and returns the registers to their defaults.
module encoder_speed_pi_controller_core import escpi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready
);

  cfg_t      cfg;
  logic      item_ready;
  logic      spd_valid;
  logic      spd_ready;
  spd_item_t spd;
  logic      stp_valid;
  logic      stp_ready;
  stp_item_t stp;

  assign item_stall = !item_ready;

  // Configuration registers.
  escpi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Encoder travel and running speed.
  escpi_speed u_speed (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .spd_valid  (spd_valid),
    .spd        (spd),
    .spd_ready  (spd_ready)
  );

  // PI update and tick step.
  escpi_pi u_pi (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .spd_valid (spd_valid),
    .spd       (spd),
    .spd_ready (spd_ready),
    .stp_valid (stp_valid),
    .stp       (stp),
    .stp_ready (stp_ready)
  );

  // Interpolated drive and result register.
  escpi_interp u_interp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .stp_valid    (stp_valid),
    .stp          (stp),
    .stp_ready    (stp_ready),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

  // An empty result register lets every stage move, so the input is open.
  a_open_when_drained: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("item_stall high while the result register is empty");

  // A beat held between the speed and PI stages must not change or vanish.
  a_spd_holds: assert property (@(posedge clk) disable iff (rst)
    spd_valid && !spd_ready |=> spd_valid && $stable(spd))
    else $error("speed beat changed while held");

  // A beat held between the PI and interpolation stages must not change or vanish.
  a_stp_holds: assert property (@(posedge clk) disable iff (rst)
    stp_valid && !stp_ready |=> stp_valid && $stable(stp))
    else $error("step beat changed while held");

endmodule

### rtl/core/escpi_regs.sv
// APB-style configuration registers of the encoder speed PI controller.
// Depends on escpi_pkg for the register map and the cfg_t bundle.
module escpi_regs import escpi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes in the access phase; indexes past the map are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_speed <= '0;
      cfg.prop_gain    <= '0;
      cfg.integ_gain   <= '0;
      cfg.drive_max    <= DRIVE_FULL_MAX;
      cfg.drive_min    <= DRIVE_FULL_MIN;
      cfg.step_offset  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TARGET_SPEED: cfg.target_speed <= pwdata[TARGET_W-1:0];
        REG_PROP_GAIN:    cfg.prop_gain    <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN:   cfg.integ_gain   <= pwdata[GAIN_W-1:0];
        REG_DRIVE_MAX:    cfg.drive_max    <= pwdata[DRIVE_W-1:0];
        REG_DRIVE_MIN:    cfg.drive_min    <= pwdata[DRIVE_W-1:0];
        REG_STEP_OFFSET:  cfg.step_offset  <= pwdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back; signed registers are sign-extended to the bus width.
  always_comb begin
    case (reg_idx)
      REG_TARGET_SPEED: prdata = APB_W'(cfg.target_speed);
      REG_PROP_GAIN:    prdata = APB_W'(cfg.prop_gain);
      REG_INTEG_GAIN:   prdata = APB_W'(cfg.integ_gain);
      REG_DRIVE_MAX:    prdata = APB_W'(cfg.drive_max);
      REG_DRIVE_MIN:    prdata = APB_W'(cfg.drive_min);
      REG_STEP_OFFSET:  prdata = APB_W'(cfg.step_offset);
      default:          prdata = '0;
    endcase
  end

endmodule

### rtl/core/escpi_speed.sv
// Input register and speed stage: encoder travel, running speed and speed error.
// Depends on escpi_pkg for item_t, spd_item_t and cfg_t.
module escpi_speed import escpi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      item_valid,
  input  item_t     item,
  output logic      item_ready,
  output logic      spd_valid,
  output spd_item_t spd,
  input  logic      spd_ready
);

  localparam int SPD_DIFF_W = ((POS_SUM_W > SPEED_W) ? POS_SUM_W : SPEED_W) + 1;

  localparam logic signed [POS_DIFF_W-1:0] POS_HALF     = POS_DIFF_W'(2 ** (POSITION_BITS - 1));
  localparam logic signed [POS_DIFF_W-1:0] POS_NEG_HALF = -POS_HALF;
  // One full turn; it wraps to its own negative in this width, which is harmless
  // because the corrected delta always lands inside half a turn.
  localparam logic signed [POS_DIFF_W-1:0] POS_FULL     = POS_DIFF_W'(2 ** POSITION_BITS);

  localparam logic signed [SPD_DIFF_W-1:0] SPD_HI = SPD_DIFF_W'((2 ** (SPEED_W - 1)) - 1);
  localparam logic signed [SPD_DIFF_W-1:0] SPD_LO = -SPD_HI - SPD_DIFF_W'(1);

  function automatic logic signed [POS_DIFF_W-1:0] wrap_delta(
    input logic signed [POS_DIFF_W-1:0] d
  );
    logic signed [POS_DIFF_W-1:0] r;
    if (d > POS_HALF) begin
      r = d - POS_FULL;
    end else if (d < POS_NEG_HALF) begin
      r = d + POS_FULL;
    end else begin
      r = d;
    end
    return r;
  endfunction

  logic                         v1;
  item_t                        s1;
  logic                         ready1;
  logic                         ready2;
  logic [POSITION_BITS-1:0]     last_left;
  logic [POSITION_BITS-1:0]     last_right;
  logic signed [SPEED_W-1:0]    speed_accum;
  logic signed [POS_DIFF_W-1:0] dl;
  logic signed [POS_DIFF_W-1:0] dr;
  logic signed [POS_SUM_W-1:0]  travel;
  logic signed [SPD_DIFF_W-1:0] speed_wide;
  logic signed [SPEED_W-1:0]    speed_new;
  spd_item_t                    spd_next;

  assign ready2     = !spd_valid || spd_ready;
  assign ready1     = !v1 || ready2;
  assign item_ready = ready1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && ready1) begin
      s1 <= item;
    end
  end

  // Wheel travel, running speed with saturation, and the error against target.
  always_comb begin
    dl         = wrap_delta($signed({1'b0, s1.left_position}) - $signed({1'b0, last_left}));
    dr         = wrap_delta($signed({1'b0, last_right}) - $signed({1'b0, s1.right_position}));
    travel     = POS_SUM_W'(dl) + POS_SUM_W'(dr);
    speed_wide = SPD_DIFF_W'(speed_accum) - SPD_DIFF_W'(travel);
    if (speed_wide > SPD_HI) begin
      speed_new = SPD_HI[SPEED_W-1:0];
    end else if (speed_wide < SPD_LO) begin
      speed_new = SPD_LO[SPEED_W-1:0];
    end else begin
      speed_new = speed_wide[SPEED_W-1:0];
    end

    spd_next.kind       = s1.kind;
    spd_next.tick_index = s1.tick_index;
    spd_next.err        = ERR_W'(cfg.target_speed) - ERR_W'(speed_new);
    spd_next.speed      = (s1.kind == KIND_UPDATE) ? speed_new : speed_accum;
  end

  // Speed stage: the wheel state moves only on an update beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      spd_valid   <= 1'b0;
      last_left   <= '0;
      last_right  <= '0;
      speed_accum <= '0;
    end else begin
      if (ready2) begin
        spd_valid <= v1;
      end
      if (v1 && ready2 && s1.kind == KIND_UPDATE) begin
        last_left   <= s1.left_position;
        last_right  <= s1.right_position;
        speed_accum <= speed_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && ready2) begin
      spd <= spd_next;
    end
  end

endmodule

### rtl/core/escpi_pi.sv
// PI stages: gain products, integrator, new and old output, and the scaled tick step.
// Depends on escpi_pkg for spd_item_t, stp_item_t, cfg_t and the clamp functions.
module escpi_pi import escpi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      spd_valid,
  input  spd_item_t spd,
  output logic      spd_ready,
  output logic      stp_valid,
  output stp_item_t stp,
  input  logic      stp_ready
);

  typedef struct packed {
    logic                      kind;
    logic [TICK_W-1:0]         tick_index;
    logic signed [SPEED_W-1:0] speed;
    logic signed [TERM_W-1:0]  p_term;
    logic signed [TERM_W-1:0]  i_term;
  } gain_item_t;

  typedef struct packed {
    logic                      kind;
    logic [TICK_W-1:0]         tick_index;
    logic signed [SPEED_W-1:0] speed;
    logic signed [TERM_W-1:0]  p_term;
    logic signed [DRIVE_W-1:0] integ;
  } integ_item_t;

  logic                          va;
  logic                          vb;
  gain_item_t                    pa;
  gain_item_t                    pa_next;
  integ_item_t                   pb;
  integ_item_t                   pb_next;
  stp_item_t                     stp_next;
  logic                          ready_a;
  logic                          ready_b;
  logic                          ready_c;
  logic signed [GAIN_PROD_W-1:0] prod_p;
  logic signed [GAIN_PROD_W-1:0] prod_i;
  logic signed [DRIVE_W-1:0]     integrator;
  logic signed [DRIVE_W-1:0]     out_new;
  logic signed [DRIVE_W-1:0]     out_old;
  logic signed [CLAMP_W-1:0]     integ_sum;
  logic signed [CLAMP_W-1:0]     out_sum;
  logic signed [STEP_W-1:0]      step;
  logic signed [STEP_W-1:0]      step_abs;
  logic [TICK_W:0]               tick_count;

  assign ready_c   = !stp_valid || stp_ready;
  assign ready_b   = !vb || ready_c;
  assign ready_a   = !va || ready_b;
  assign spd_ready = ready_a;

  // Gain stage: both products of the error, with the Q8.8 fraction floored away.
  always_comb begin
    prod_p             = spd.err * $signed({1'b0, cfg.prop_gain});
    prod_i             = spd.err * $signed({1'b0, cfg.integ_gain});
    pa_next.kind       = spd.kind;
    pa_next.tick_index = spd.tick_index;
    pa_next.speed      = spd.speed;
    pa_next.p_term     = TERM_W'(prod_p >>> FRAC_BITS);
    pa_next.i_term     = TERM_W'(prod_i >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ready_a) begin
      va <= spd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (spd_valid && ready_a) begin
      pa <= pa_next;
    end
  end

  // Integrator stage: clamp the stored value, add the integral term, saturate.
  always_comb begin
    integ_sum = CLAMP_W'(clamp_drive(CLAMP_W'(integrator), cfg.drive_max, cfg.drive_min))
              + CLAMP_W'(pa.i_term);
    pb_next.kind       = pa.kind;
    pb_next.tick_index = pa.tick_index;
    pb_next.speed      = pa.speed;
    pb_next.p_term     = pa.p_term;
    pb_next.integ      = sat_drive(integ_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb         <= 1'b0;
      integrator <= '0;
    end else begin
      if (ready_b) begin
        vb <= va;
      end
      if (va && ready_b && pa.kind == KIND_UPDATE) begin
        integrator <= pb_next.integ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (va && ready_b) begin
      pb <= pb_next;
    end
  end

  // Output stage: an update rolls the outputs forward; a tick scales the step
  // between them, with the offset pushed away from zero, by the tick count.
  always_comb begin
    out_sum    = CLAMP_W'(pb.integ) + CLAMP_W'(pb.p_term);
    step       = STEP_W'(out_new) - STEP_W'(out_old);
    if (step > 0) begin
      step = step + STEP_W'($signed({1'b0, cfg.step_offset}));
    end else if (step < 0) begin
      step = step - STEP_W'($signed({1'b0, cfg.step_offset}));
    end
    step_abs   = (step < 0) ? -step : step;
    tick_count = {1'b0, pb.tick_index} + (TICK_W + 1)'(1);

    stp_next.kind    = pb.kind;
    stp_next.speed   = pb.speed;
    stp_next.neg     = step[STEP_W-1];
    stp_next.mag     = MAG_W'(step_abs[STEP_W-2:0]) * MAG_W'(tick_count);
    stp_next.out_old = out_old;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stp_valid <= 1'b0;
      out_new   <= '0;
      out_old   <= '0;
    end else begin
      if (ready_c) begin
        stp_valid <= vb;
      end
      if (vb && ready_c && pb.kind == KIND_UPDATE) begin
        out_old <= clamp_drive(CLAMP_W'(out_new), cfg.drive_max, cfg.drive_min);
        out_new <= sat_drive(out_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vb && ready_c) begin
      stp <= stp_next;
    end
  end

endmodule

### rtl/core/escpi_interp.sv
// Interpolation stages: division of the scaled step by the step count,
// then offset by the old output, clamping, and the result register.
// Depends on escpi_pkg for stp_item_t, result_t, cfg_t and clamp_drive.
module escpi_interp import escpi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      stp_valid,
  input  stp_item_t stp,
  output logic      stp_ready,
  output logic      result_valid,
  output result_t   result,
  input  logic      result_stall
);

  localparam int RPROD_W = MAG_W + RECIP_W;

  typedef struct packed {
    logic                      kind;
    logic signed [SPEED_W-1:0] speed;
    logic                      neg;
    logic [QUOT_W-1:0]         quot;
    logic signed [DRIVE_W-1:0] out_old;
  } quot_item_t;

  logic                      vd;
  quot_item_t                pd;
  quot_item_t                pd_next;
  logic                      ready_d;
  logic                      ready_e;
  logic [RPROD_W-1:0]        rprod;
  logic signed [CLAMP_W-1:0] quot_signed;
  logic signed [CLAMP_W-1:0] drive_sum;
  logic signed [DRIVE_W-1:0] drive_new;
  logic signed [DRIVE_W-1:0] drive_hold;
  result_t                   result_next;

  assign ready_e   = !result_valid || !result_stall;
  assign ready_d   = !vd || ready_e;
  assign stp_ready = ready_d;

  // Quotient stage: magnitude times the reciprocal, upper bits kept.
  always_comb begin
    rprod           = RPROD_W'(stp.mag) * RPROD_W'(RECIP_STEPS);
    pd_next.kind    = stp.kind;
    pd_next.speed   = stp.speed;
    pd_next.neg     = stp.neg;
    pd_next.quot    = rprod[RPROD_W-1:RECIP_SHIFT];
    pd_next.out_old = stp.out_old;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (ready_d) begin
      vd <= stp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stp_valid && ready_d) begin
      pd <= pd_next;
    end
  end

  // Result stage: the sign goes back on (rounding toward zero), then the old
  // output is added and the sum clamped. An update reports the held drive.
  always_comb begin
    quot_signed = CLAMP_W'($signed({1'b0, pd.quot}));
    if (pd.neg) begin
      quot_signed = -quot_signed;
    end
    drive_sum  = quot_signed + CLAMP_W'(pd.out_old);
    drive_new  = clamp_drive(drive_sum, cfg.drive_max, cfg.drive_min);

    result_next.motor_drive    = (pd.kind == KIND_TICK) ? drive_new : drive_hold;
    result_next.measured_speed = pd.speed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      drive_hold   <= '0;
    end else begin
      if (ready_e) begin
        result_valid <= vd;
      end
      if (vd && ready_e && pd.kind == KIND_TICK) begin
        drive_hold <= drive_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vd && ready_e) begin
      result <= result_next;
    end
  end

endmodule

### tb/encoder_speed_pi_controller_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for encoder_speed_pi_controller_core: a directed table, then random
// encoder and tick traffic, checked by typed rows or a built-in predictor. Needs escpi_pkg, RTL.
module encoder_speed_pi_controller_core_tb;
  import escpi_pkg::*;

  localparam int CLK_HALF          = 5;
  localparam int RESET_CYCLES      = 12;
  // The item path is seven registers deep; this covers it with margin.
  localparam int DRAIN_CYCLES      = 12;
  // Longest quiet stretch of a correct run is the longest sender gap or receiver
  // stall plus a pipeline drain and register access; this is many times that.
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int PHASE_ITEMS       = 100;
  localparam int RANDOM_PHASES     = 6;
  localparam int DIRECTED_SETTINGS = 4;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = REG_IDX_W'(6);
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = REG_IDX_W'(7);

  localparam longint SPEED_TOP    = (longint'(1) << (SPEED_W - 1)) - 1;
  localparam longint SPEED_BOTTOM = -(longint'(1) << (SPEED_W - 1));
  localparam longint DRIVE_TOP    = DRIVE_FULL_MAX;
  localparam longint DRIVE_BOTTOM = DRIVE_FULL_MIN;
  localparam longint TURN         = longint'(1) << POSITION_BITS;
  localparam longint HALF_TURN    = TURN / 2;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  item_t             item         = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  result_t           result;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [ADDR_W-1:0] paddr        = '0;
  logic [APB_W-1:0]  pwdata       = '0;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  encoder_speed_pi_controller_core i_dut (.*);

  always #CLK_HALF clk = ~clk;

  // Predictor state: register copy plus encoder, speed and drive state.
  cfg_t                      cfg_shadow;
  logic [POSITION_BITS-1:0]  trk_left;
  logic [POSITION_BITS-1:0]  trk_right;
  logic signed [SPEED_W-1:0] trk_speed;
  logic signed [DRIVE_W-1:0] trk_integ;
  logic signed [DRIVE_W-1:0] trk_out_new;
  logic signed [DRIVE_W-1:0] trk_out_old;
  logic signed [DRIVE_W-1:0] trk_drive;

  result_t pending_results[$];
  result_t head_result;
  int      mismatch_count = 0;
  int      idle_cycles    = 0;
  int      stall_left     = 0;
  int      stall_pick     = 0;
  bit      tx_calm        = 1'b0;
  bit      rx_calm        = 1'b0;

  typedef struct {
    int      setting;
    item_t   it;
    bit      typed;
    result_t want;
  } stim_row_t;

  stim_row_t directed_rows[$];
  cfg_t      directed_cfg[DIRECTED_SETTINGS];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  function automatic longint sat_to(input longint x, input longint lo, input longint hi);
    return (x > hi) ? hi : ((x < lo) ? lo : x);
  endfunction

  // Configured clamp; with crossed limits, values above the upper one get it, all others the lower.
  function automatic longint limit_drive(input longint x);
    longint hi;
    longint lo;
    hi = $signed(cfg_shadow.drive_max);
    lo = $signed(cfg_shadow.drive_min);
    if (x > hi) begin
      return hi;
    end else if (x < lo) begin
      return lo;
    end
    return x;
  endfunction

  // Encoder travel folded into plus or minus half a turn.
  function automatic longint wrap_travel(input longint d);
    if (d > HALF_TURN) begin
      return d - TURN;
    end else if (d < -HALF_TURN) begin
      return d + TURN;
    end
    return d;
  endfunction

  // Advance the speed and drive state by one item and return its result beat.
  function automatic result_t advance_drive_model(input item_t it);
    longint  dl, dr, spd, err, p_term, i_term, step;
    result_t r;
    if (it.kind == KIND_UPDATE) begin
      dl = wrap_travel(longint'(it.left_position) - longint'(trk_left));
      dr = wrap_travel(longint'(trk_right) - longint'(it.right_position));
      trk_left  = it.left_position;
      trk_right = it.right_position;
      spd = sat_to(longint'(trk_speed) - (dl + dr), SPEED_BOTTOM, SPEED_TOP);
      trk_speed = SPEED_W'(spd);
      err = longint'($signed(cfg_shadow.target_speed)) - spd;
      p_term = (err * longint'(cfg_shadow.prop_gain)) >>> FRAC_BITS;
      i_term = (err * longint'(cfg_shadow.integ_gain)) >>> FRAC_BITS;
      trk_integ   = DRIVE_W'(sat_to(limit_drive(trk_integ) + i_term, DRIVE_BOTTOM, DRIVE_TOP));
      trk_out_old = DRIVE_W'(limit_drive(trk_out_new));
      trk_out_new = DRIVE_W'(sat_to(longint'(trk_integ) + p_term, DRIVE_BOTTOM, DRIVE_TOP));
    end else begin
      step = longint'(trk_out_new) - longint'(trk_out_old);
      if (step > 0) begin
        step += longint'(cfg_shadow.step_offset);
      end else if (step < 0) begin
        step -= longint'(cfg_shadow.step_offset);
      end
      trk_drive = DRIVE_W'(limit_drive(step * (longint'(it.tick_index) + 1) / INTERP_STEPS
                                       + longint'(trk_out_old)));
    end
    r.motor_drive    = trk_drive;
    r.measured_speed = trk_speed;
    return r;
  endfunction

  // Register value as the predictor holds it, and the bits it occupies.
  function automatic void shadow_reg(input logic [REG_IDX_W-1:0] idx,
                                     output logic [APB_W-1:0] val,
                                     output logic [APB_W-1:0] mask);
    int width;
    case (idx)
      REG_TARGET_SPEED: begin
        val = APB_W'($unsigned(cfg_shadow.target_speed));
        width = TARGET_W;
      end
      REG_PROP_GAIN: begin
        val = APB_W'(cfg_shadow.prop_gain);
        width = GAIN_W;
      end
      REG_INTEG_GAIN: begin
        val = APB_W'(cfg_shadow.integ_gain);
        width = GAIN_W;
      end
      REG_DRIVE_MAX: begin
        val = APB_W'($unsigned(cfg_shadow.drive_max));
        width = DRIVE_W;
      end
      REG_DRIVE_MIN: begin
        val = APB_W'($unsigned(cfg_shadow.drive_min));
        width = DRIVE_W;
      end
      REG_STEP_OFFSET: begin
        val = APB_W'(cfg_shadow.step_offset);
        width = OFFSET_W;
      end
      default: begin
        val = '0;
        width = 0;
      end
    endcase
    mask = APB_W'((64'd1 << width) - 1);
  endfunction

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_TARGET_SPEED: cfg_shadow.target_speed = value[TARGET_W-1:0];
      REG_PROP_GAIN:    cfg_shadow.prop_gain    = value[GAIN_W-1:0];
      REG_INTEG_GAIN:   cfg_shadow.integ_gain   = value[GAIN_W-1:0];
      REG_DRIVE_MAX:    cfg_shadow.drive_max    = value[DRIVE_W-1:0];
      REG_DRIVE_MIN:    cfg_shadow.drive_min    = value[DRIVE_W-1:0];
      REG_STEP_OFFSET:  cfg_shadow.step_offset  = value[OFFSET_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [REG_IDX_W-1:0] idx, output logic [APB_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_pipeline_empty();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Program a full register set once the pipeline is empty, then read it back.
  task automatic apply_setting(input cfg_t c);
    logic [APB_W-1:0] got, want, mask;
    wait_pipeline_empty();
    apb_write(REG_TARGET_SPEED, APB_W'(c.target_speed));
    apb_write(REG_PROP_GAIN, APB_W'(c.prop_gain));
    apb_write(REG_INTEG_GAIN, APB_W'(c.integ_gain));
    apb_write(REG_DRIVE_MAX, APB_W'(c.drive_max));
    apb_write(REG_DRIVE_MIN, APB_W'(c.drive_min));
    apb_write(REG_STEP_OFFSET, APB_W'(c.step_offset));
    apb_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    for (int k = 0; k < NUM_REGS; k++) begin
      apb_read(REG_IDX_W'(k), got);
      shadow_reg(REG_IDX_W'(k), want, mask);
      if ((got & mask) !== want) begin
        report_mismatch("register readback", got & mask, want);
      end
    end
  endtask

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return GAIN_W'($urandom_range(0, 512));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // Register set for one random phase; the first two hit the extremes, the second and third cross the limits.
  function automatic cfg_t random_setting(input int ph);
    cfg_t   c;
    longint a, b, t;
    a = $signed(DRIVE_W'($urandom));
    b = $signed(DRIVE_W'($urandom));
    if ($urandom_range(0, 1)) begin
      a = a >>> 6;
      b = b >>> 6;
    end
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    c.target_speed = TARGET_W'($urandom);
    c.prop_gain    = rand_gain();
    c.integ_gain   = rand_gain();
    c.step_offset  = $urandom_range(0, 1) ? OFFSET_W'($urandom_range(0, 255))
                                          : OFFSET_W'($urandom);
    c.drive_min    = DRIVE_W'(a);
    c.drive_max    = DRIVE_W'(b);
    if ($urandom_range(0, 9) < 3) begin
      c.drive_min = DRIVE_FULL_MIN;
      c.drive_max = DRIVE_FULL_MAX;
    end
    case (ph)
      0: begin
        c.target_speed = {1'b0, {(TARGET_W - 1){1'b1}}};
        c.prop_gain    = '1;
        c.integ_gain   = '1;
        c.drive_min    = DRIVE_FULL_MIN;
        c.drive_max    = DRIVE_FULL_MAX;
        c.step_offset  = '1;
      end
      1: begin
        c.target_speed = {1'b1, {(TARGET_W - 1){1'b0}}};
        c.prop_gain    = '0;
        c.integ_gain   = '1;
        c.drive_min    = DRIVE_FULL_MAX;
        c.drive_max    = DRIVE_FULL_MIN;
        c.step_offset  = '0;
      end
      2: begin
        c.drive_min = DRIVE_W'(b);
        c.drive_max = DRIVE_W'(a);
      end
      default: ;
    endcase
    return c;
  endfunction

  // Sender gap before a beat: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Offer one beat, hold it until taken, and queue what it should produce.
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    int      gap;
    result_t model_out;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall !== 1'b0);
    model_out = advance_drive_model(it);
    pending_results.push_back(typed ? want : model_out);
  endtask

  task automatic add_row(input int setting, input logic kind, input int left, input int right,
                         input int tick, input bit typed, input int drive, input int speed);
    stim_row_t row;
    row.setting                 = setting;
    row.it.kind                 = kind;
    row.it.left_position        = POSITION_BITS'(left);
    row.it.right_position       = POSITION_BITS'(right);
    row.it.tick_index           = TICK_W'(tick);
    row.typed                   = typed;
    row.want.motor_drive        = DRIVE_W'(drive);
    row.want.measured_speed     = SPEED_W'(speed);
    directed_rows.push_back(row);
  endtask

  // Receiver stall pattern, with calm stretches when asked.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (rx_calm) begin
      result_stall <= 1'b0;
      stall_left   <= $urandom_range(4, 30);
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        result_stall <= 1'b0;
        stall_left   <= $urandom_range(0, 4);
      end else if (stall_pick < 93) begin
        result_stall <= 1'b1;
        stall_left   <= $urandom_range(0, 2);
      end else begin
        result_stall <= 1'b1;
        stall_left   <= $urandom_range(9, 39);
      end
    end
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected, drive",
                        $signed(result.motor_drive), 0);
      end else begin
        head_result = pending_results.pop_front();
        if (result.motor_drive !== head_result.motor_drive) begin
          report_mismatch("motor_drive", $signed(result.motor_drive),
                          $signed(head_result.motor_drive));
        end
        if (result.measured_speed !== head_result.measured_speed) begin
          report_mismatch("measured_speed", $signed(result.measured_speed),
                          $signed(head_result.measured_speed));
        end
      end
    end
  end

  // End the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((item_valid && item_stall === 1'b0) || (result_valid === 1'b1 && !result_stall) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("encoder_speed_pi_controller_core verification failed");
      $finish;
    end
  end

  initial begin
    item_t                    it;
    int                       cur_setting;
    int                       phase_items;
    int                       tick_count;
    int                       left_vel;
    int                       right_vel;
    int                       dir;
    bit                       spin;
    logic [POSITION_BITS-1:0] left_pos;
    logic [POSITION_BITS-1:0] right_pos;

    // Setting 0 is the reset state; the others are the directed register sets.
    directed_cfg[0] = '{target_speed: '0, prop_gain: '0, integ_gain: '0,
                        drive_max: DRIVE_FULL_MAX, drive_min: DRIVE_FULL_MIN,
                        step_offset: '0};
    directed_cfg[1] = '{target_speed: {1'b0, {(TARGET_W - 1){1'b1}}}, prop_gain: '1,
                        integ_gain: '1, drive_max: DRIVE_FULL_MAX,
                        drive_min: DRIVE_FULL_MIN, step_offset: '1};
    // Crossed limits.
    directed_cfg[2] = '{target_speed: {1'b1, {(TARGET_W - 1){1'b0}}}, prop_gain: 16'd256,
                        integ_gain: '0, drive_max: -24'sd1000, drive_min: 24'sd1000,
                        step_offset: '0};
    directed_cfg[3] = '{target_speed: 13'sd100, prop_gain: 16'd384, integ_gain: 16'd32,
                        drive_max: 24'sd5000, drive_min: -24'sd5000, step_offset: 16'd7};

    cfg_shadow  = directed_cfg[0];
    trk_left    = '0;
    trk_right   = '0;
    trk_speed   = '0;
    trk_integ   = '0;
    trk_out_new = '0;
    trk_out_old = '0;
    trk_drive   = '0;

    // Reset state: zero gains keep the drive at zero, only the speed moves.
    // Tick with the ignored position fields at their top values.
    add_row(0, KIND_TICK,   1023, 1023, 15, 1'b1, 0, 0);
    add_row(0, KIND_UPDATE,    0,    0, 15, 1'b1, 0, 0);
    // Left travel of exactly half a turn stays positive.
    add_row(0, KIND_UPDATE,  512,    0,  0, 1'b1, 0, -512);
    add_row(0, KIND_UPDATE,    0,  512,  0, 1'b1, 0, 512);
    // Both wheels wrap across the zero position.
    add_row(0, KIND_UPDATE, 1023, 1023,  0, 1'b1, 0, 1024);
    add_row(0, KIND_UPDATE,    0,    0,  0, 1'b1, 0, 1024);
    add_row(0, KIND_TICK,      0,    0,  0, 1'b1, 0, 1024);
    // Full gains and offset: large steps, tick indexes past the last step.
    add_row(1, KIND_UPDATE,    0,    0,  0, 1'b0, 0, 0);
    add_row(1, KIND_TICK,      0,    0,  0, 1'b0, 0, 0);
    add_row(1, KIND_TICK,      0,    0,  4, 1'b0, 0, 0);
    add_row(1, KIND_TICK,      0,    0,  8, 1'b0, 0, 0);
    add_row(1, KIND_TICK,      0,    0,  9, 1'b0, 0, 0);
    add_row(1, KIND_TICK,      0,    0, 15, 1'b0, 0, 0);
    add_row(1, KIND_UPDATE,  511,  513,  0, 1'b0, 0, 0);
    add_row(1, KIND_TICK,      0,    0,  8, 1'b0, 0, 0);
    add_row(1, KIND_UPDATE, 1023,    1,  0, 1'b0, 0, 0);
    add_row(1, KIND_TICK,      0,    0, 15, 1'b0, 0, 0);
    // Crossed limits.
    add_row(2, KIND_UPDATE,    0,    0,  0, 1'b0, 0, 0);
    add_row(2, KIND_TICK,      0,    0,  8, 1'b0, 0, 0);
    add_row(2, KIND_TICK,      0,    0, 15, 1'b0, 0, 0);
    add_row(2, KIND_UPDATE,  512,  512,  0, 1'b0, 0, 0);
    add_row(2, KIND_TICK,      0,    0,  3, 1'b0, 0, 0);
    // Narrow limits with a small step offset.
    add_row(3, KIND_UPDATE,  100,  924,  0, 1'b0, 0, 0);
    add_row(3, KIND_TICK,      0,    0,  0, 1'b0, 0, 0);
    add_row(3, KIND_TICK,      0,    0,  8, 1'b0, 0, 0);
    add_row(3, KIND_UPDATE,  200,  824,  0, 1'b0, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    cur_setting = 0;
    foreach (directed_rows[n]) begin
      if (directed_rows[n].setting != cur_setting) begin
        item_valid <= 1'b0;
        apply_setting(directed_cfg[directed_rows[n].setting]);
        cur_setting = directed_rows[n].setting;
      end
      send_item(directed_rows[n].it, directed_rows[n].typed, directed_rows[n].want);
    end
    item_valid <= 1'b0;

    // Random phases: wheel motion sequences with interpolation ticks, plus noise.
    left_pos  = directed_rows[directed_rows.size() - 1].it.left_position;
    right_pos = directed_rows[directed_rows.size() - 1].it.right_position;
    left_vel  = 0;
    right_vel = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_setting(random_setting(ph));
      spin = (ph < 2) || ($urandom_range(0, 3) == 0);
      if (spin) begin
        dir = $urandom_range(0, 1) ? 1 : -1;
        left_vel  = dir * int'($urandom_range(470, 512));
        right_vel = dir * int'($urandom_range(470, 512));
      end
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 8) begin
          it.kind           = $urandom_range(0, 1) ? KIND_TICK : KIND_UPDATE;
          it.left_position  = POSITION_BITS'($urandom);
          it.right_position = POSITION_BITS'($urandom);
          it.tick_index     = TICK_W'($urandom);
          send_item(it, 1'b0, '0);
          phase_items++;
        end else begin
          if (!spin) begin
            if ($urandom_range(0, 99) < 12) begin
              left_vel  = int'($urandom_range(0, 1024)) - 512;
              right_vel = int'($urandom_range(0, 1024)) - 512;
            end else begin
              left_vel  = left_vel + int'($urandom_range(0, 16)) - 8;
              right_vel = right_vel + int'($urandom_range(0, 16)) - 8;
              left_vel  = (left_vel > 512) ? 512 : ((left_vel < -512) ? -512 : left_vel);
              right_vel = (right_vel > 512) ? 512 : ((right_vel < -512) ? -512 : right_vel);
            end
          end
          if ($urandom_range(0, 99) < 5) begin
            left_pos = POSITION_BITS'($urandom);
          end
          left_pos  = POSITION_BITS'(int'(left_pos) + left_vel);
          right_pos = POSITION_BITS'(int'(right_pos) - right_vel);
          it.kind           = KIND_UPDATE;
          it.left_position  = left_pos;
          it.right_position = right_pos;
          it.tick_index     = TICK_W'($urandom);
          send_item(it, 1'b0, '0);
          phase_items++;
          tick_count = spin ? $urandom_range(0, 2) : $urandom_range(0, 10);
          for (int k = 0; k < tick_count; k++) begin
            it.kind           = KIND_TICK;
            it.left_position  = POSITION_BITS'($urandom);
            it.right_position = POSITION_BITS'($urandom);
            it.tick_index     = ($urandom_range(0, 9) == 0) ? TICK_W'($urandom) : TICK_W'(k);
            send_item(it, 1'b0, '0);
            phase_items++;
          end
        end
      end
      item_valid <= 1'b0;
    end

    wait_pipeline_empty();
    if (mismatch_count == 0) begin
      $display("encoder_speed_pi_controller_core verification clean");
    end else begin
      $display("encoder_speed_pi_controller_core verification failed");
    end
    $finish;
  end

endmodule
